### hdl/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // Default geometry of the free bitmaps.
    localparam int LEAF_BLOCKS_DEF = 128;
    localparam int LEVELS_DEF      = 4;

    // Payload widths.
    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 19;
    localparam int LEVEL_W  = 2;
    localparam int MLOG_W   = 4;

    // Legal span of the smallest block size, as log2 of bytes.
    localparam logic [MLOG_W-1:0] MIN_LOG2_LOW   = 4'd4;
    localparam logic [MLOG_W-1:0] MIN_LOG2_HIGH  = 4'd12;
    localparam logic [MLOG_W-1:0] MIN_LOG2_RESET = 4'd4;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_MIN_BLOCK_LOG2 = 1'b0;

    typedef enum logic [1:0] {
        STATUS_GRANTED   = 2'd0,
        STATUS_ZERO_SIZE = 2'd1,
        STATUS_TOO_LARGE = 2'd2,
        STATUS_NO_FREE   = 2'd3
    } status_t;

endpackage

`default_nettype wire

### hdl/bba_if.sv
// Valid/ready channel interfaces for allocation requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if
    import bba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output request_size, input ready);
    modport sink   (input valid, input request_size, output ready);
endinterface

interface bba_rsp_if
    import bba_pkg::*;
();
    logic                valid;
    logic                ready;
    status_t             status;
    logic [OFFSET_W-1:0] block_offset;
    logic [LEVEL_W-1:0]  block_level;

    modport source (output valid, output status, output block_offset,
                    output block_level, input ready);
    modport sink   (input valid, input status, input block_offset,
                    input block_level, output ready);
endinterface

`default_nettype wire

### hdl/bba_ffs.sv
// Find-first-set over one level of the free bitmap.
`timescale 1ns / 1ps
`default_nettype none

module bba_ffs
    import bba_pkg::*;
#(
    parameter int WIDTH = LEAF_BLOCKS_DEF,
    parameter int IDX_W = $clog2(LEAF_BLOCKS_DEF)
)
(
    input  wire logic [WIDTH-1:0] bits,
    output logic                  any,
    output logic [IDX_W-1:0]      idx
);

    logic [WIDTH-1:0] lowest;

    // Isolate the lowest set bit with one carry chain, then encode the one-hot word.
    assign lowest = bits & (~bits + WIDTH'(1));
    assign any    = |bits;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: request path, free bitmaps and APB register.
`timescale 1ns / 1ps
`default_nettype none

// A request accepted into the input register moves on to the output register when that
// register is empty or its item is being taken, and the result is offered from there.
// Throughput: one item per cycle while results are taken. The loop that sets this is the
// free-map search (one find-first-set per level) and the bitmap update written back with it.
// Reset (rst_n, asynchronous, active low): every block of the top level is free, all other
// levels are empty, the smallest block size reverts to 16 bytes and both stages are empty.

module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int LEAF_BLOCKS = LEAF_BLOCKS_DEF,
    parameter int LEVELS      = LEVELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bba_req_if.sink                    req,
    bba_rsp_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W      = $clog2(LEAF_BLOCKS);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int SH_W       = $clog2(int'(MIN_LOG2_HIGH) + LEVELS);
    localparam int TOP_BLOCKS = LEAF_BLOCKS >> (LEVELS - 1);
    localparam int WIDE_W     = IDX_W + int'(MIN_LOG2_HIGH);

    // Reset contents of the top row: its live blocks are all free.
    localparam logic [LEAF_BLOCKS-1:0] TOP_FREE = LEAF_BLOCKS'({TOP_BLOCKS{1'b1}});

    // ------------------------------------------------------------------
    // Configuration register. The raw value is kept for read-back; the
    // clamped copy is what the size comparison uses.
    // ------------------------------------------------------------------
    logic [MLOG_W-1:0] mlog_raw_reg;
    logic [MLOG_W-1:0] mlog_reg;
    logic [MLOG_W-1:0] mlog_clamped;
    logic              cfg_write;
    logic              cfg_hit;

    assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == REG_MIN_BLOCK_LOG2);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign pready    = 1'b1;
    assign prdata    = cfg_hit ? APB_DATA_W'(mlog_raw_reg) : '0;

    always_comb
    begin
        priority if (pwdata[MLOG_W-1:0] < MIN_LOG2_LOW)
        begin
            mlog_clamped = MIN_LOG2_LOW;
        end
        else if (pwdata[MLOG_W-1:0] > MIN_LOG2_HIGH)
        begin
            mlog_clamped = MIN_LOG2_HIGH;
        end
        else
        begin
            mlog_clamped = pwdata[MLOG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mlog_raw_reg <= MIN_LOG2_RESET;
            mlog_reg     <= MIN_LOG2_RESET;
        end
        else if (cfg_write)
        begin
            mlog_raw_reg <= pwdata[MLOG_W-1:0];
            mlog_reg     <= mlog_clamped;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register takes a new item when it is empty or the
    // item it holds moves on in the same cycle; the output register moves
    // when it is empty or its item is being taken.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic              out_free;
    logic              commit;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign commit    = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_size_reg <= req.request_size;
        end
    end

    // ------------------------------------------------------------------
    // Level selection. A level covers the request when its block size,
    // 2^(mlog+l), is at least the size, that is when (size-1) shifted
    // right by mlog+l is zero.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_m1;
    logic [LEVELS-1:0] lvl_ok;
    logic              size_zero;
    logic              size_fits;
    logic [LVL_W-1:0]  req_lvl;

    assign size_zero = (s1_size_reg == '0);
    assign size_m1   = s1_size_reg - SIZE_W'(1);
    assign size_fits = |lvl_ok;

    always_comb
    begin
        logic [SH_W-1:0] sh;
        sh = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            sh        = SH_W'(mlog_reg) + SH_W'(l);
            lvl_ok[l] = ((size_m1 >> sh) == '0);
        end
    end

    // The covering levels form an upper run, so the lowest set flag wins.
    always_comb
    begin
        req_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (lvl_ok[l])
            begin
                req_lvl = LVL_W'(l);
            end
        end
    end

    // ------------------------------------------------------------------
    // Free bitmaps. Row l holds LEAF_BLOCKS >> l live bits; the bits above
    // that stay zero because no update ever addresses them.
    // ------------------------------------------------------------------
    logic [LEVELS-1:0][LEAF_BLOCKS-1:0] free_map_reg;
    logic [LEVELS-1:0][LEAF_BLOCKS-1:0] free_map_next;
    logic [LEVELS-1:0]                  level_any;
    logic [IDX_W-1:0]                   level_idx [LEVELS];

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        localparam int LW = LEAF_BLOCKS >> l;
        if (LW > 0)
        begin : g_search
            bba_ffs #(
                .WIDTH (LW),
                .IDX_W (IDX_W)
            ) u_ffs (
                .bits (free_map_reg[l][LW-1:0]),
                .any  (level_any[l]),
                .idx  (level_idx[l])
            );
        end
        else
        begin : g_empty
            assign level_any[l] = 1'b0;
            assign level_idx[l] = '0;
        end
    end

    // Nearest level at or above the requested one that still has a free block.
    logic              found;
    logic [LVL_W-1:0]  avail_lvl;
    logic [IDX_W-1:0]  avail_idx;
    logic              grant;
    status_t           status_next;

    always_comb
    begin
        found     = 1'b0;
        avail_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (level_any[l] && (LVL_W'(l) >= req_lvl))
            begin
                found     = 1'b1;
                avail_lvl = LVL_W'(l);
            end
        end
    end

    assign avail_idx = level_idx[avail_lvl];
    assign grant     = !size_zero && size_fits && found;

    always_comb
    begin
        priority if (size_zero)
        begin
            status_next = STATUS_ZERO_SIZE;
        end
        else if (!size_fits)
        begin
            status_next = STATUS_TOO_LARGE;
        end
        else if (!found)
        begin
            status_next = STATUS_NO_FREE;
        end
        else
        begin
            status_next = STATUS_GRANTED;
        end
    end

    // Splitting a block down from avail_lvl to req_lvl clears the chosen
    // block and leaves the right buddy free on every level it passes
    // through; the left buddies are taken in turn, and they were not free
    // before because those levels had no free block at all. The right
    // buddy index is the chosen index shifted to that level with its low
    // bit set, which always lies inside the level.
    always_comb
    begin
        logic [IDX_W-1:0] right_idx;
        logic             clr;
        logic             set;
        right_idx     = '0;
        clr           = 1'b0;
        set           = 1'b0;
        free_map_next = free_map_reg;
        for (int k = 0; k < LEVELS; k++)
        begin
            right_idx = (avail_idx << (avail_lvl - LVL_W'(k))) | IDX_W'(1);
            for (int i = 0; i < LEAF_BLOCKS; i++)
            begin
                clr = (LVL_W'(k) == avail_lvl) && (IDX_W'(i) == avail_idx);
                set = (LVL_W'(k) >= req_lvl) && (LVL_W'(k) < avail_lvl)
                      && (IDX_W'(i) == right_idx);
                if (commit && grant)
                begin
                    free_map_next[k][i] = (free_map_reg[k][i] && !clr) || set;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                free_map_reg[l] <= (l == LEVELS - 1) ? TOP_FREE : '0;
            end
        end
        else
        begin
            free_map_reg <= free_map_next;
        end
    end

    // ------------------------------------------------------------------
    // Granted block position. The leaf index of the block start is the
    // index at the level it was found on, shifted down to leaf level.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  leaf;
    logic [WIDE_W-1:0] offset_wide;

    assign leaf        = avail_idx << avail_lvl;
    assign offset_wide = WIDE_W'(leaf) << mlog_reg;

    // Request size kept per leaf for the free path, which lives elsewhere.
    logic [SIZE_W-1:0] size_mem [LEAF_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (commit && grant)
        begin
            size_mem[leaf] <= s1_size_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= status_next;
            out_offset_reg <= grant ? OFFSET_W'(offset_wide) : '0;
            out_level_reg  <= grant ? LEVEL_W'(req_lvl) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.block_offset = out_offset_reg;
    assign rsp.block_level  = out_level_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fail_keeps_map : assert property (@(posedge clk) disable iff (!rst_n)
        commit && !grant |=> $stable(free_map_reg))
        else $error("free map changed on a failed request");

    a_grant_changes_map : assert property (@(posedge clk) disable iff (!rst_n)
        commit && grant |=> !$stable(free_map_reg))
        else $error("grant left the free map untouched");

    a_grant_hits_free : assert property (@(posedge clk) disable iff (!rst_n)
        commit && grant |-> free_map_reg[avail_lvl][avail_idx] && avail_lvl >= req_lvl)
        else $error("granted a block that was not free");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("input taken while both stages are held");

    a_fail_zero_fields : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_GRANTED
        |-> out_offset_reg == '0 && out_level_reg == '0)
        else $error("failed result carries a non-zero position");

endmodule

`default_nettype wire
